@@ rtl/decimal_line_command_parser_core_defines.svh @@
// -----------------------------------------------------------------------------
// Decimal line command parser - assertion macros
// Shared property shorthands for the port-level checker.
// -----------------------------------------------------------------------------
`ifndef DECIMAL_LINE_COMMAND_PARSER_CORE_DEFINES_SVH
`define DECIMAL_LINE_COMMAND_PARSER_CORE_DEFINES_SVH

// same-cycle implication, reset masked
`define DLCP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define DLCP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/dlcp_pkg.sv @@
// -----------------------------------------------------------------------------
// dlcp_pkg
// Widths, command codes, register indexes, reset values and character codes of the parser.
// -----------------------------------------------------------------------------
package dlcp_pkg;

	localparam int VAL_W = 31;
	localparam int CMD_W = 2;
	localparam int CHAR_W = 8;
	localparam int CFG_IDX_W = 2;

	localparam logic [VAL_W-1:0] VAL_MAX = {VAL_W{1'b1}};

	// transaction commands
	localparam logic [CMD_W-1:0] CMD_CHAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_MIN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COMMAND_MAX = 2'd1;

	localparam logic [VAL_W-1:0] COMMAND_MIN_RST = 31'd0;
	localparam logic [VAL_W-1:0] COMMAND_MAX_RST = 31'd100;

	localparam logic [CHAR_W-1:0] CH_LF   = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR   = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE = 8'h39;

endpackage

@@ rtl/decimal_line_command_parser_core.sv @@
// A result is presented in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle while the input is not stalled; the line state and the x10 multiply-add
// sit between the input handshake and the result register.
// Input stalls only while the result register is full and the output is stalled.
// Reset (arst_n low, asynchronous): line state and pending command cleared,
// command_min = 0, command_max = 100, result register empty.
// -----------------------------------------------------------------------------
// decimal_line_command_parser_core
// Builds decimal lines from received characters and holds one pending command.
// -----------------------------------------------------------------------------
module decimal_line_command_parser_core #(
	parameter int LINE_BUFFER_LEN = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [dlcp_pkg::CMD_W-1:0]      cmd,
	input  logic [dlcp_pkg::CHAR_W-1:0]     char_in,
	input  logic                            consumer_busy,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            command_pending,
	output logic                            command_delivered,
	output logic [dlcp_pkg::VAL_W-1:0]      command_value,
	input  logic                            cfg_we,
	input  logic [dlcp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dlcp_pkg::VAL_W-1:0]      cfg_wdata
);
	import dlcp_pkg::*;

	localparam int CNT_W = $clog2(LINE_BUFFER_LEN);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(LINE_BUFFER_LEN - 1);
	localparam int PROD_W = VAL_W + 4;

	logic [VAL_W-1:0] command_min_q, command_max_q;

	logic [CNT_W-1:0] char_count_q, char_count_d;
	logic [VAL_W-1:0] running_value_q, running_value_d;
	logic             saw_non_digit_q, saw_non_digit_d;
	logic             value_too_large_q, value_too_large_d;
	logic             pending_flag_q, pending_flag_d;
	logic [VAL_W-1:0] pending_value_q, pending_value_d;

	logic             res_valid_q;
	logic             res_pending_q;
	logic             res_delivered_q, delivered_d;
	logic [VAL_W-1:0] res_value_q, value_d;

	logic              in_fire;
	logic              is_digit;
	logic              line_ok;
	logic [PROD_W-1:0] run_ext;
	logic [PROD_W-1:0] next_value;
	logic              next_over;

	assign in_stall = res_valid_q & out_stall;
	assign in_fire  = in_valid & ~in_stall;

	assign out_valid         = res_valid_q;
	assign command_pending   = res_pending_q;
	assign command_delivered = res_delivered_q;
	assign command_value     = res_value_q;

	// value * 10 + digit as (v << 3) + (v << 1) + d
	assign is_digit   = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
	assign run_ext    = PROD_W'(running_value_q);
	assign next_value = (run_ext << 3) + (run_ext << 1) + PROD_W'(char_in[3:0]);
	assign next_over  = next_value > PROD_W'(VAL_MAX);

	assign line_ok = (char_count_q != '0) && !saw_non_digit_q && !value_too_large_q &&
	                 (running_value_q >= command_min_q) && (running_value_q <= command_max_q);

	always_comb begin
		char_count_d      = char_count_q;
		running_value_d   = running_value_q;
		saw_non_digit_d   = saw_non_digit_q;
		value_too_large_d = value_too_large_q;
		pending_flag_d    = pending_flag_q;
		pending_value_d   = pending_value_q;
		delivered_d       = 1'b0;
		value_d           = '0;
		case (cmd)
			CMD_CHAR: begin
				if (!consumer_busy && !pending_flag_q) begin
					if (char_in == CH_LF || char_in == CH_CR) begin
						if (line_ok) begin
							pending_flag_d  = 1'b1;
							pending_value_d = running_value_q;
						end
						char_count_d      = '0;
						running_value_d   = '0;
						saw_non_digit_d   = 1'b0;
						value_too_large_d = 1'b0;
					end else if (char_count_q < CNT_LIMIT) begin
						char_count_d = char_count_q + 1'b1;
						if (is_digit) begin
							if (value_too_large_q || next_over) begin
								value_too_large_d = 1'b1;
								running_value_d   = VAL_MAX;
							end else begin
								running_value_d = next_value[VAL_W-1:0];
							end
						end else begin
							saw_non_digit_d = 1'b1;
						end
					end else begin
						// line overflow: drop the line and this character
						char_count_d      = '0;
						running_value_d   = '0;
						saw_non_digit_d   = 1'b0;
						value_too_large_d = 1'b0;
					end
				end
			end
			CMD_TAKE: begin
				if (pending_flag_q) begin
					delivered_d     = 1'b1;
					value_d         = pending_value_q;
					pending_flag_d  = 1'b0;
					pending_value_d = '0;
				end
			end
			CMD_CLEAR: begin
				char_count_d      = '0;
				running_value_d   = '0;
				saw_non_digit_d   = 1'b0;
				value_too_large_d = 1'b0;
				pending_flag_d    = 1'b0;
				pending_value_d   = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_min_q <= COMMAND_MIN_RST;
			command_max_q <= COMMAND_MAX_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_COMMAND_MIN) begin
				command_min_q <= cfg_wdata;
			end else if (cfg_index == REG_COMMAND_MAX) begin
				command_max_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_count_q      <= '0;
			running_value_q   <= '0;
			saw_non_digit_q   <= 1'b0;
			value_too_large_q <= 1'b0;
			pending_flag_q    <= 1'b0;
			pending_value_q   <= '0;
		end else if (in_fire) begin
			char_count_q      <= char_count_d;
			running_value_q   <= running_value_d;
			saw_non_digit_q   <= saw_non_digit_d;
			value_too_large_q <= value_too_large_d;
			pending_flag_q    <= pending_flag_d;
			pending_value_q   <= pending_value_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (in_fire) begin
			res_valid_q <= 1'b1;
		end else if (!out_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			res_pending_q   <= pending_flag_d;
			res_delivered_q <= delivered_d;
			res_value_q     <= value_d;
		end
	end

endmodule

@@ rtl/dlcp_checker.sv @@
// -----------------------------------------------------------------------------
// dlcp_checker
// Port-level checks of the parser core, bound into the parser core module.
// -----------------------------------------------------------------------------
`include "decimal_line_command_parser_core_defines.svh"

module dlcp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic [dlcp_pkg::CMD_W-1:0]      cmd,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic                            command_pending,
	input logic                            command_delivered,
	input logic [dlcp_pkg::VAL_W-1:0]      command_value
);
	import dlcp_pkg::*;

	logic in_fire;
	logic out_fire;

	assign in_fire  = in_valid & ~in_stall;
	assign out_fire = out_valid & ~out_stall;

	`DLCP_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(command_pending) && $stable(command_delivered) && $stable(command_value), "stalled result changed")
	`DLCP_ASSERT_NOW(a_deliver_clears, clk, arst_n, out_valid && command_delivered, !command_pending, "pending still set after delivery")
	`DLCP_ASSERT_NOW(a_value_zero, clk, arst_n, out_valid && !command_delivered, command_value == '0, "value nonzero without delivery")
	`DLCP_ASSERT_NEXT(a_clear_result, clk, arst_n, in_fire && cmd == CMD_CLEAR, out_valid && !command_pending && !command_delivered, "clear left a command pending")
	`DLCP_ASSERT_NEXT(a_no_phantom, clk, arst_n, out_fire && !in_fire, !out_valid, "result without a transaction")

endmodule

bind decimal_line_command_parser_core dlcp_checker u_dlcp_checker (.*);

@@ tb/tb_decimal_line_command_parser_core.sv @@
// -----------------------------------------------------------------------------
// tb_decimal_line_command_parser_core
// Drives characters, take and clear transactions into the line parser and
// checks every result against a cycle-free model of the line state. A fixed
// script covers the corner cases. Random lines then follow under several
// command ranges and handshake idling profiles.
// -----------------------------------------------------------------------------
module tb_decimal_line_command_parser_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dlcp_pkg::*;

	localparam int LINE_LEN = 16;
	localparam int NUM_PHASES = 8;
	localparam int ITEMS_PER_PHASE = 140;
	localparam int CYCLE_LIMIT = 400000;
	localparam int N_ROWS = 32;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	// indexes with no register behind them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	typedef struct packed {
		logic             pending;
		logic             delivered;
		logic [VAL_W-1:0] value;
	} parse_result_t;

	typedef struct packed {
		logic [CMD_W-1:0]  op;
		logic [CHAR_W-1:0] ch;
		logic              busy;
		logic [4:0]        reps;
		logic              typed;
		parse_result_t     want;
	} script_row_t;

	localparam parse_result_t NO_CMD = '0;
	localparam parse_result_t HELD = {1'b1, 1'b0, 31'd0};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [CMD_W-1:0]     cmd = CMD_CHAR;
	logic [CHAR_W-1:0]    char_in = '0;
	logic                 consumer_busy = 1'b0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic                 command_pending;
	logic                 command_delivered;
	logic [VAL_W-1:0]     command_value;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_COMMAND_MIN;
	logic [VAL_W-1:0]     cfg_wdata = '0;

	// model of the parser
	int               line_count = 0;
	logic [VAL_W-1:0] line_value = '0;
	bit               line_bad_char = 0;
	bit               line_too_big = 0;
	bit               cmd_waiting = 0;
	logic [VAL_W-1:0] cmd_held = '0;
	logic [VAL_W-1:0] range_lo = COMMAND_MIN_RST;
	logic [VAL_W-1:0] range_hi = COMMAND_MAX_RST;

	parse_result_t     due_results[$];
	logic [CHAR_W-1:0] line_buf[$];
	int                errors = 0;
	int                item_count = 0;
	int                cycle_count = 0;
	int                tx_idle_pct = 0;
	int                rx_stall_pct = 0;

	script_row_t script [0:N_ROWS-1] = '{
		'{CMD_TAKE,   8'h00, 1'b0, 5'd1,  1'b1, NO_CMD}, // take with nothing pending
		'{CMD_CHAR,   CH_LF, 1'b0, 5'd1,  1'b1, NO_CMD}, // empty line
		'{CMD_CHAR,   "1",   1'b0, 5'd1,  1'b0, NO_CMD},
		'{CMD_CHAR,   "0",   1'b0, 5'd2,  1'b0, NO_CMD},
		'{CMD_CHAR,   CH_CR, 1'b0, 5'd1,  1'b1, HELD},   // 100 is the top of the range
		'{CMD_CHAR,   "5",   1'b0, 5'd1,  1'b1, HELD},   // dropped while pending
		'{CMD_TAKE,   8'hFF, 1'b1, 5'd1,  1'b1, {1'b0, 1'b1, 31'd100}},
		'{CMD_TAKE,   8'h00, 1'b0, 5'd1,  1'b1, NO_CMD},
		'{CMD_CHAR,   "7",   1'b1, 5'd1,  1'b0, NO_CMD}, // consumer busy
		'{CMD_CHAR,   CH_LF, 1'b0, 5'd1,  1'b1, NO_CMD},
		'{CMD_CHAR,   "0",   1'b0, 5'd1,  1'b0, NO_CMD},
		'{CMD_CHAR,   CH_CR, 1'b0, 5'd1,  1'b1, HELD},   // 0 is the bottom of the range
		'{CMD_UNUSED, 8'hA5, 1'b1, 5'd1,  1'b1, HELD},
		'{CMD_CLEAR,  8'h00, 1'b1, 5'd1,  1'b1, NO_CMD},
		'{CMD_CHAR,   "1",   1'b0, 5'd1,  1'b0, NO_CMD},
		'{CMD_CHAR,   "0",   1'b0, 5'd1,  1'b0, NO_CMD},
		'{CMD_CHAR,   "1",   1'b0, 5'd1,  1'b0, NO_CMD},
		'{CMD_CHAR,   CH_LF, 1'b0, 5'd1,  1'b1, NO_CMD}, // above range
		'{CMD_CHAR,   8'hFF, 1'b0, 5'd1,  1'b0, NO_CMD},
		'{CMD_CHAR,   "5",   1'b0, 5'd1,  1'b0, NO_CMD},
		'{CMD_CHAR,   CH_CR, 1'b0, 5'd1,  1'b1, NO_CMD}, // non-digit in line
		'{CMD_CHAR,   "3",   1'b0, 5'd1,  1'b0, NO_CMD},
		'{CMD_CLEAR,  8'h00, 1'b0, 5'd1,  1'b1, NO_CMD},
		'{CMD_CHAR,   CH_LF, 1'b0, 5'd1,  1'b1, NO_CMD}, // line gone after clear
		'{CMD_CHAR,   "9",   1'b0, 5'd10, 1'b0, NO_CMD},
		'{CMD_CHAR,   CH_CR, 1'b0, 5'd1,  1'b1, NO_CMD}, // saturated value
		'{CMD_CHAR,   "9",   1'b0, 5'd15, 1'b0, NO_CMD},
		'{CMD_CHAR,   8'h00, 1'b0, 5'd1,  1'b0, NO_CMD}, // overflows the line
		'{CMD_CHAR,   "4",   1'b0, 5'd1,  1'b0, NO_CMD},
		'{CMD_CHAR,   "2",   1'b0, 5'd1,  1'b0, NO_CMD},
		'{CMD_CHAR,   CH_LF, 1'b0, 5'd1,  1'b1, HELD},
		'{CMD_TAKE,   8'h00, 1'b0, 5'd1,  1'b1, {1'b0, 1'b1, 31'd42}}
	};

	decimal_line_command_parser_core #(
		.LINE_BUFFER_LEN(LINE_LEN)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cmd(cmd),
		.char_in(char_in),
		.consumer_busy(consumer_busy),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.command_pending(command_pending),
		.command_delivered(command_delivered),
		.command_value(command_value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= (rx_stall_pct != 0) && ($urandom_range(99) < rx_stall_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin : result_check
		parse_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_results.size() == 0) begin
				$error("result with no transaction outstanding");
				errors++;
			end else begin
				want = due_results.pop_front();
				if (command_pending !== want.pending) begin
					$error("command_pending: expected %0d, got %0d", want.pending,
						command_pending);
					errors++;
				end
				if (command_delivered !== want.delivered) begin
					$error("command_delivered: expected %0d, got %0d", want.delivered,
						command_delivered);
					errors++;
				end
				if (command_value !== want.value) begin
					$error("command_value: expected %0d, got %0d", want.value,
						command_value);
					errors++;
				end
			end
		end
	end

	task automatic drop_line();
		line_count = 0;
		line_value = '0;
		line_bad_char = 0;
		line_too_big = 0;
	endtask

	task automatic parse_step(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] c,
			input logic busy_in, output parse_result_t r);
		longint unsigned next_val;
		r = '0;
		case (op)
			CMD_CHAR: begin
				if (busy_in || cmd_waiting) begin
					// character ignored
				end else if (c == CH_LF || c == CH_CR) begin
					if (line_count > 0 && !line_bad_char && !line_too_big &&
						line_value >= range_lo && line_value <= range_hi) begin
						cmd_waiting = 1;
						cmd_held = line_value;
					end
					drop_line();
				end else if (line_count < LINE_LEN - 1) begin
					line_count++;
					if (c >= CH_ZERO && c <= CH_NINE) begin
						next_val = 64'(line_value) * 64'd10 + 64'(c - CH_ZERO);
						if (line_too_big || next_val > 64'(VAL_MAX)) begin
							line_too_big = 1;
							line_value = VAL_MAX;
						end else begin
							line_value = next_val[VAL_W-1:0];
						end
					end else begin
						line_bad_char = 1;
					end
				end else begin
					drop_line();
				end
			end
			CMD_TAKE: begin
				if (cmd_waiting) begin
					r.delivered = 1'b1;
					r.value = cmd_held;
					cmd_waiting = 0;
					cmd_held = '0;
				end
			end
			CMD_CLEAR: begin
				drop_line();
				cmd_waiting = 0;
				cmd_held = '0;
			end
			default: ;
		endcase
		r.pending = cmd_waiting;
	endtask

	// present one transaction and hold it until accepted
	task automatic send_item(input logic [CMD_W-1:0] op, input logic [CHAR_W-1:0] c,
			input logic busy_in, input bit typed, input parse_result_t typed_res);
		parse_result_t got;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		char_in <= c;
		consumer_busy <= busy_in;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		parse_step(op, c, busy_in, got);
		due_results.push_back(typed ? typed_res : got);
		item_count++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic program_range(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi,
			input bit spare);
		cfg_we <= 1'b1;
		cfg_index <= REG_COMMAND_MIN;
		cfg_wdata <= lo;
		@(posedge clk);
		range_lo = lo;
		cfg_index <= REG_COMMAND_MAX;
		cfg_wdata <= hi;
		@(posedge clk);
		range_hi = hi;
		if (spare) begin
			cfg_index <= REG_SPARE_2;
			cfg_wdata <= VAL_W'($urandom);
			@(posedge clk);
			cfg_index <= REG_SPARE_3;
			cfg_wdata <= VAL_W'($urandom);
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	function automatic logic [CHAR_W-1:0] other_char();
		logic [CHAR_W-1:0] b;
		do begin
			b = CHAR_W'($urandom_range(255));
		end while (b == CH_LF || b == CH_CR || (b >= CH_ZERO && b <= CH_NINE));
		return b;
	endfunction

	// values near and inside the current range, plus a few out of 31 bits
	function automatic longint unsigned pick_value();
		longint unsigned lo;
		longint unsigned hi;
		lo = range_lo;
		hi = range_hi;
		case ($urandom_range(9))
			0: return lo;
			1: return hi;
			2: return (lo == 0) ? 0 : lo - 1;
			3: return hi + 1;
			4: return $urandom_range(999);
			5: return 64'($urandom) & 64'(VAL_MAX);
			6: return 64'h8000_0000 + $urandom_range(9999);
			default: return (hi >= lo) ? lo + 64'($urandom) % (hi - lo + 1) : 
				64'($urandom_range(999));
		endcase
	endfunction

	task automatic add_number(input longint unsigned v);
		logic [CHAR_W-1:0] digits[$];
		do begin
			digits.push_front(CH_ZERO + CHAR_W'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digits[i]) line_buf.push_back(digits[i]);
	endtask

	task automatic random_burst();
		int k;
		int pos;
		k = $urandom_range(99);
		line_buf.delete();
		if (k < 55) begin
			if ($urandom_range(4) == 0) repeat ($urandom_range(1, 2)) line_buf.push_back(CH_ZERO);
			add_number(pick_value());
		end else if (k < 65) begin
			add_number(64'h8000_0000 + 64'($urandom) * $urandom_range(1, 2000));
		end else if (k < 75) begin
			add_number(pick_value());
			pos = $urandom_range(line_buf.size() - 1);
			line_buf[pos] = other_char();
		end else if (k < 82) begin
			repeat (LINE_LEN + $urandom_range(4))
				line_buf.push_back(($urandom_range(3) != 0) ?
					CH_ZERO + CHAR_W'($urandom_range(9)) : other_char());
		end
		if (k < 82) begin
			foreach (line_buf[i]) send_item(CMD_CHAR, line_buf[i], $urandom_range(19) == 0, 0, '0);
			send_item(CMD_CHAR, $urandom_range(1) ? CH_CR : CH_LF, $urandom_range(19) == 0, 0, '0);
			if ($urandom_range(3) != 0)
				send_item(CMD_TAKE, CHAR_W'($urandom), $urandom_range(1), 0, '0);
		end else if (k < 92) begin
			send_item(CMD_W'($urandom_range(3)), CHAR_W'($urandom_range(255)),
				$urandom_range(1), 0, '0);
		end else begin
			send_item($urandom_range(1) ? CMD_CLEAR : CMD_TAKE, CHAR_W'($urandom),
				$urandom_range(1), 0, '0);
		end
	endtask

	initial begin
		logic [VAL_W-1:0] lo;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < NUM_PHASES; phase++) begin
			case (phase % 4)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 84; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 84; end
				default: begin tx_idle_pct = 14; rx_stall_pct = 14; end
			endcase
			if (phase != 0) settle();
			case (phase)
				0: begin
					// reset range; scripted corner cases first
					foreach (script[i])
						for (int r = 0; r < script[i].reps; r++)
							send_item(script[i].op, script[i].ch, script[i].busy,
								script[i].typed && r == script[i].reps - 1, script[i].want);
				end
				1: program_range('0, VAL_MAX, 0);
				2: program_range(VAL_MAX, VAL_MAX, 0);
				3: program_range(31'd50, 31'd49, 0); // empty range
				4: begin
					lo = VAL_W'($urandom_range(500));
					program_range(lo, lo + VAL_W'($urandom_range(1, 5000)), 0);
				end
				5: program_range('0, '0, 0);
				6: begin
					lo = VAL_W'($urandom) >> 1;
					program_range(lo, lo + VAL_W'($urandom_range(1000000)), 0);
				end
				default: begin
					lo = VAL_W'($urandom_range(10, 99));
					program_range(lo, lo, 1);
				end
			endcase
			item_count = 0;
			while (item_count < ITEMS_PER_PHASE) random_burst();
		end
		settle();
		repeat (8) @(posedge clk);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
